### rtl/core/lbfg_pkg.sv
`default_nettype none

package lbfg_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int LOAD_W = 7;
  localparam int HIST_W = 8;
  localparam int DL_W   = 16;
  localparam int IDX_W  = 3;

  // Default widths of the time totals and frequency values.
  localparam int TIME_WIDTH_DEF = 32;
  localparam int FREQ_WIDTH_DEF = 32;

  // Percent scale used by the load and downscale arithmetic.
  localparam logic [LOAD_W-1:0] PCT_FULL = 7'd100;

  // The divide by 100 of the scaled frequency takes one 16-bit digit per step.
  // Every partial dividend stays below 100 * 2^16, where
  // floor(x / 100) equals (x * SCALE_RECIP) >> SCALE_SHIFT exactly.
  localparam int DIG_W       = 16;
  localparam int PART_W      = LOAD_W + DIG_W;
  localparam int RECIP_W     = 24;
  localparam int RPRD_W      = PART_W + RECIP_W;
  localparam int SCALE_SHIFT = 30;
  localparam logic [RECIP_W-1:0] SCALE_RECIP = 24'd10737419;

  // Register indexes.
  localparam logic [IDX_W-1:0] REG_UP_THR   = 3'd0;
  localparam logic [IDX_W-1:0] REG_DOWN_THR = 3'd1;
  localparam logic [IDX_W-1:0] REG_HISTORY  = 3'd2;
  localparam logic [IDX_W-1:0] REG_DEADLINE = 3'd3;
  localparam logic [IDX_W-1:0] REG_MAX_FREQ = 3'd4;

  // Register reset values.
  localparam logic [LOAD_W-1:0] UP_THR_RST   = 7'd80;
  localparam logic [LOAD_W-1:0] DOWN_THR_RST = 7'd30;
  localparam logic [HIST_W-1:0] HISTORY_RST  = 8'd5;
  localparam logic [DL_W-1:0]   DEADLINE_RST = 16'd16;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic delta;
    logic prep;
    logic div_step;
    logic decide;
    logic mul;
    logic scale_step;
    logic load_out;
  } lbfg_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first_pending;
    logic zero_sum;
    logic down_req;
  } lbfg_sts_t;

endpackage

`default_nettype wire

### rtl/core/lbfg_datapath.sv
`default_nettype none

module lbfg_datapath import lbfg_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF,
  parameter int CFG_W      = (FREQ_WIDTH > DL_W) ? FREQ_WIDTH : DL_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire lbfg_cmd_t             cmd,
  output lbfg_sts_t                  sts,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic [TIME_WIDTH-1:0] in_total_active,
  input  wire logic [TIME_WIDTH-1:0] in_total_idle,
  input  wire logic [FREQ_WIDTH-1:0] in_current_freq,
  output logic                       out_request_valid,
  output logic [FREQ_WIDTH-1:0]      out_requested_freq,
  output logic [LOAD_W-1:0]          out_load_percent
);

  localparam int NUM_W = TIME_WIDTH + LOAD_W;
  localparam int PRD_W = FREQ_WIDTH + LOAD_W;
  localparam int N_DIG = (PRD_W + DIG_W - 1) / DIG_W;
  localparam int PAD_W = N_DIG * DIG_W;
  localparam int CMP_W = (TIME_WIDTH > DL_W) ? TIME_WIDTH : DL_W;

  // Configuration registers.
  logic [LOAD_W-1:0]     up_thr_r;
  logic [LOAD_W-1:0]     down_thr_r;
  logic [HIST_W-1:0]     history_r;
  logic [DL_W-1:0]       deadline_r;
  logic [FREQ_WIDTH-1:0] max_freq_r;

  // Governor state.
  logic                  first_r;
  logic [TIME_WIDTH-1:0] prev_act_r;
  logic [TIME_WIDTH-1:0] prev_idle_r;
  logic [HIST_W-1:0]     low_count_r;
  logic [LOAD_W-1:0]     load_value_r;

  // Working registers of the current item.
  logic [TIME_WIDTH-1:0] act_r;
  logic [TIME_WIDTH-1:0] idle_r;
  logic [FREQ_WIDTH-1:0] cur_r;
  logic [TIME_WIDTH-1:0] da_r;
  logic [TIME_WIDTH-1:0] di_r;
  logic [NUM_W-1:0]      rem_r;
  logic [NUM_W-1:0]      dv_r;
  logic [LOAD_W-1:0]     q_r;
  logic [PAD_W-1:0]      prod_r;
  logic [LOAD_W-1:0]     srem_r;
  logic                  req_r;
  logic                  down_r;

  // Output payload registers.
  logic                  out_req_r;
  logic [FREQ_WIDTH-1:0] out_freq_r;
  logic [LOAD_W-1:0]     out_load_r;

  // Load numerator 100 * active and the shifted divisor (active + idle) * 64.
  logic [NUM_W-1:0]      da_ext;
  logic [NUM_W-1:0]      num_100;
  logic [TIME_WIDTH:0]   sum_w;

  // Decision terms.
  logic                  dl_hit;
  logic [LOAD_W-1:0]     load_eff;
  logic [HIST_W-1:0]     lc_eff;
  logic                  up_hit;
  logic                  low_hit;
  logic                  down_now;
  logic [HIST_W-1:0]     lc_next;

  // Division steps.
  logic                  div_ge;
  logic [PART_W-1:0]     s_part;
  logic [RPRD_W-1:0]     s_recip;
  logic [DIG_W-1:0]      s_qdig;
  logic [PART_W-1:0]     s_back;

  always_comb begin
    da_ext  = {{LOAD_W{1'b0}}, da_r};
    num_100 = (da_ext << 6) + (da_ext << 5) + (da_ext << 2);
    sum_w   = {1'b0, da_r} + {1'b0, di_r};
  end

  // Decide on a request from the fresh load figure.
  always_comb begin
    dl_hit   = CMP_W'(da_r) > CMP_W'(deadline_r);
    load_eff = sts.zero_sum ? load_value_r : q_r;
    lc_eff   = dl_hit ? '0 : low_count_r;
    up_hit   = load_eff >= up_thr_r;
    low_hit  = load_eff <= down_thr_r;
    down_now = !up_hit && low_hit && (lc_eff == history_r);
    if (up_hit || !low_hit || down_now) begin
      lc_next = '0;
    end else begin
      lc_next = lc_eff + 1'b1;
    end
  end

  // One quotient bit per step for the load; one 16-bit quotient digit per
  // step for the divide by 100, formed by reciprocal multiplication.
  always_comb begin
    div_ge  = rem_r >= dv_r;
    s_part  = {srem_r, prod_r[PAD_W-1 -: DIG_W]};
    s_recip = RPRD_W'(s_part) * RPRD_W'(SCALE_RECIP);
    s_qdig  = s_recip[SCALE_SHIFT +: DIG_W];
    s_back  = s_part - PART_W'(s_qdig) * PART_W'(PCT_FULL);
  end

  always_comb begin
    sts.first_pending = first_r;
    sts.zero_sum      = (da_r == '0) && (di_r == '0);
    sts.down_req      = down_now;
  end

  // Configuration and governor state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      up_thr_r     <= UP_THR_RST;
      down_thr_r   <= DOWN_THR_RST;
      history_r    <= HISTORY_RST;
      deadline_r   <= DEADLINE_RST;
      max_freq_r   <= '1;
      first_r      <= 1'b1;
      prev_act_r   <= '0;
      prev_idle_r  <= '0;
      low_count_r  <= '0;
      load_value_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_UP_THR: begin
            up_thr_r    <= cfg_wdata[LOAD_W-1:0];
            low_count_r <= '0;
          end
          REG_DOWN_THR: begin
            down_thr_r  <= cfg_wdata[LOAD_W-1:0];
            low_count_r <= '0;
          end
          REG_HISTORY: begin
            history_r   <= cfg_wdata[HIST_W-1:0];
            low_count_r <= '0;
          end
          REG_DEADLINE: deadline_r <= cfg_wdata[DL_W-1:0];
          REG_MAX_FREQ: max_freq_r <= cfg_wdata[FREQ_WIDTH-1:0];
          default: ;
        endcase
      end
      if (cmd.latch_in && first_r) begin
        first_r     <= 1'b0;
        prev_act_r  <= in_total_active;
        prev_idle_r <= in_total_idle;
      end
      if (cmd.delta) begin
        prev_act_r  <= act_r;
        prev_idle_r <= idle_r;
      end
      if (cmd.decide) begin
        load_value_r <= load_eff;
        low_count_r  <= lc_next;
      end
    end
  end

  // Working registers: deltas, load division and frequency scaling.
  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      act_r  <= in_total_active;
      idle_r <= in_total_idle;
      cur_r  <= in_current_freq;
      req_r  <= 1'b0;
      down_r <= 1'b0;
    end
    if (cmd.delta) begin
      da_r <= act_r - prev_act_r;
      di_r <= idle_r - prev_idle_r;
    end
    if (cmd.prep) begin
      rem_r <= num_100;
      dv_r  <= {sum_w[NUM_W-7:0], 6'b0};
      q_r   <= '0;
    end
    if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - dv_r;
      end
      dv_r <= dv_r >> 1;
      q_r  <= {q_r[LOAD_W-2:0], div_ge};
    end
    if (cmd.decide) begin
      req_r  <= dl_hit || up_hit || down_now;
      down_r <= down_now;
    end
    if (cmd.mul) begin
      prod_r <= PAD_W'(cur_r) * PAD_W'(load_value_r);
      srem_r <= '0;
    end
    if (cmd.scale_step) begin
      srem_r <= s_back[LOAD_W-1:0];
      prod_r <= (prod_r << DIG_W) | PAD_W'(s_qdig);
    end
    if (cmd.load_out) begin
      out_req_r  <= req_r;
      out_load_r <= load_value_r;
      if (down_r) begin
        out_freq_r <= prod_r[FREQ_WIDTH-1:0];
      end else if (req_r) begin
        out_freq_r <= max_freq_r;
      end else begin
        out_freq_r <= '0;
      end
    end
  end

  assign out_request_valid  = out_req_r;
  assign out_requested_freq = out_freq_r;
  assign out_load_percent   = out_load_r;

`ifndef SYNTHESIS
  // The held load figure never leaves the percent range.
  a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> load_value_r <= PCT_FULL)
    else $error("load figure above 100 percent");

  // A loaded result without a request carries a zero frequency.
  a_no_req_zero: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.load_out) && !out_req_r |-> out_freq_r == '0)
    else $error("frequency set without a request");

  // A downscale is always reported as a request.
  a_down_is_req: assert property (@(posedge clk) disable iff (!rst_n)
    $past(cmd.decide) && down_r |-> req_r)
    else $error("downscale without request");
`endif

endmodule

`default_nettype wire

### rtl/core/lbfg_ctrl.sv
`default_nettype none

module lbfg_ctrl import lbfg_pkg::*; #(
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire lbfg_sts_t sts,
  output lbfg_cmd_t      cmd
);

  localparam int PRD_W = FREQ_WIDTH + LOAD_W;
  localparam int N_DIG = (PRD_W + DIG_W - 1) / DIG_W;
  localparam int CNT_W = $clog2(PRD_W);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DELTA,
    S_PREP,
    S_DIV,
    S_DECIDE,
    S_MUL,
    S_SCALE,
    S_RESULT
  } state_t;

  state_t             state_r;
  state_t             state_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic [CNT_W-1:0]   cnt_nxt;
  logic               out_valid_r;
  logic               out_valid_nxt;
  logic               in_acc;
  logic               out_free;

  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Sequencing of one item through the datapath.
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = sts.first_pending ? S_RESULT : S_DELTA;
        end
      end
      S_DELTA: begin
        cmd.delta = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = CNT_W'(LOAD_W - 1);
        state_nxt = sts.zero_sum ? S_DECIDE : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.down_req ? S_MUL : S_RESULT;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = CNT_W'(N_DIG - 1);
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale_step = 1'b1;
        cnt_nxt        = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // State, step counter and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  // An accepted item keeps the input closed in the next cycle.
  a_busy_after_acc: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input reopened straight after an item");

  // A new result never overwrites one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("waiting result overwritten");

  // The datapath is never driven by two step commands at once.
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.div_step, cmd.scale_step, cmd.mul, cmd.decide}))
    else $error("overlapping datapath commands");
`endif

endmodule

`default_nettype wire

### rtl/core/load_based_freq_governor.sv
`default_nettype none

// Load based frequency governor.
// Input channel (in_valid/in_ready): one item per frame-done event with the
// running active and idle totals and the frequency in use. Result channel
// (out_valid/out_ready): exactly one item per input item with the request
// flag, the requested frequency (zero without a request) and the load.
// Configuration: write cfg_wdata to register cfg_index while cfg_we is high,
// only while the block is idle. Registers 0..4: up threshold, down
// threshold, history size, deadline time and maximum frequency.
// Steps from acceptance to result valid: the first event after reset goes
// straight to the result, zero deltas skip the divider, an ordinary event
// runs the serial load divider, and a downscale adds the multiply and the
// divide by 100. The load comes from a 7-step serial divider and the scaled
// frequency from a divide by 100, one 16-bit digit per cycle. One item
// is worked on at a time; the next is taken in the cycle after the result loads.
// Reset is synchronous and active low; it restores the register defaults
// and makes the next event only latch the totals. A stalled receiver holds
// the result in the output register; the next item is still accepted and
// worked on, and waits for that register to free.
module load_based_freq_governor import lbfg_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int FREQ_WIDTH = FREQ_WIDTH_DEF,
  parameter int CFG_W      = (FREQ_WIDTH > DL_W) ? FREQ_WIDTH : DL_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [IDX_W-1:0]      cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_wdata,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [TIME_WIDTH-1:0] in_total_active,
  input  wire logic [TIME_WIDTH-1:0] in_total_idle,
  input  wire logic [FREQ_WIDTH-1:0] in_current_freq,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_request_valid,
  output logic [FREQ_WIDTH-1:0]      out_requested_freq,
  output logic [LOAD_W-1:0]          out_load_percent
);

  lbfg_cmd_t cmd;
  lbfg_sts_t sts;

  // Sequencer.
  lbfg_ctrl #(
    .FREQ_WIDTH (FREQ_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic, state and registers.
  lbfg_datapath #(
    .TIME_WIDTH (TIME_WIDTH),
    .FREQ_WIDTH (FREQ_WIDTH),
    .CFG_W      (CFG_W)
  ) u_datapath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_total_active    (in_total_active),
    .in_total_idle      (in_total_idle),
    .in_current_freq    (in_current_freq),
    .out_request_valid  (out_request_valid),
    .out_requested_freq (out_requested_freq),
    .out_load_percent   (out_load_percent)
  );

endmodule

`default_nettype wire

### tb/tb_load_based_freq_governor.sv
`timescale 1ns / 100ps

module tb_load_based_freq_governor;
  import lbfg_pkg::*;

  localparam int TW = TIME_WIDTH_DEF;
  localparam int FW = FREQ_WIDTH_DEF;
  localparam int CW = (FW > DL_W) ? FW : DL_W;

  // Quiet time after the last result, above the slowest event latency.
  localparam int SETTLE_CYCLES = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int PRINT_LIMIT   = 40;

  // Indexes outside the register map, which the block must ignore.
  localparam logic [IDX_W-1:0] REG_SPARE_LO = 3'd5;
  localparam logic [IDX_W-1:0] REG_SPARE_HI = 3'd7;

  // Receiver stall patterns.
  typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_LONG} rx_mode_t;

  typedef enum logic {ROW_EVENT, ROW_WRITE} row_kind_t;

  typedef struct packed {
    logic              request;
    logic [FW-1:0]     freq;
    logic [LOAD_W-1:0] load;
  } freq_request_t;

  // One line of the directed script; events carry deltas of the totals.
  typedef struct {
    row_kind_t        kind;
    logic [IDX_W-1:0] idx;
    logic [CW-1:0]    wdata;
    logic [TW-1:0]    d_active;
    logic [TW-1:0]    d_idle;
    logic [FW-1:0]    cur_freq;
    bit               typed;
    freq_request_t    outcome;
  } script_row_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [IDX_W-1:0]  cfg_index;
  logic [CW-1:0]     cfg_wdata;
  logic              in_valid;
  logic              in_ready;
  logic [TW-1:0]     in_total_active;
  logic [TW-1:0]     in_total_idle;
  logic [FW-1:0]     in_current_freq;
  logic              out_valid;
  logic              out_ready;
  logic              out_request_valid;
  logic [FW-1:0]     out_requested_freq;
  logic [LOAD_W-1:0] out_load_percent;

  // Governor copy: registers and per-event state.
  logic [LOAD_W-1:0] gov_up_thr;
  logic [LOAD_W-1:0] gov_down_thr;
  logic [HIST_W-1:0] gov_history;
  logic [DL_W-1:0]   gov_deadline;
  logic [FW-1:0]     gov_max_freq;
  logic              gov_first;
  logic [TW-1:0]     gov_prev_active;
  logic [TW-1:0]     gov_prev_idle;
  logic [HIST_W-1:0] gov_low_count;
  logic [LOAD_W-1:0] gov_load;

  freq_request_t pending_requests[$];
  script_row_t   directed_rows[$];
  logic [TW-1:0] tot_active;
  logic [TW-1:0] tot_idle;
  int            burst_left;
  int            err_count = 0;
  int            cycle_count = 0;

  rx_mode_t      rx_mode;
  logic [7:0]    rx_tick;
  int            rx_hold;

  load_based_freq_governor dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_total_active    (in_total_active),
    .in_total_idle      (in_total_idle),
    .in_current_freq    (in_current_freq),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_request_valid  (out_request_valid),
    .out_requested_freq (out_requested_freq),
    .out_load_percent   (out_load_percent)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Works out the request for one frame-done event and advances the state.
  function automatic freq_request_t governor_step(logic [TW-1:0] act, logic [TW-1:0] idle,
                                                  logic [FW-1:0] cur);
    logic [TW-1:0] da;
    logic [TW-1:0] di;
    logic [63:0]   span;
    freq_request_t res;
    res = '0;
    if (gov_first) begin
      gov_first = 1'b0;
    end else begin
      da = act - gov_prev_active;
      di = idle - gov_prev_idle;
      if (da > gov_deadline) begin
        gov_low_count = '0;
        res.request = 1'b1;
        res.freq = gov_max_freq;
      end
      // The sum is taken at full width, so the load never exceeds 100.
      if (da != '0 || di != '0) begin
        span = 64'(da) + 64'(di);
        gov_load = LOAD_W'((64'(da) * 64'(PCT_FULL)) / span);
      end
      if (gov_load >= gov_up_thr) begin
        gov_low_count = '0;
        res.request = 1'b1;
        res.freq = gov_max_freq;
      end else if (gov_load <= gov_down_thr) begin
        if (gov_low_count == gov_history) begin
          res.request = 1'b1;
          res.freq = FW'((64'(cur) * 64'(gov_load)) / 64'(PCT_FULL));
          gov_low_count = '0;
        end else begin
          gov_low_count = gov_low_count + 1'b1;
        end
      end else begin
        gov_low_count = '0;
      end
    end
    gov_prev_active = act;
    gov_prev_idle = idle;
    res.load = gov_load;
    return res;
  endfunction

  // Register write as the block sees it; threshold and history writes restart the count.
  function automatic void governor_write(logic [IDX_W-1:0] idx, logic [CW-1:0] data);
    case (idx)
      REG_UP_THR: begin
        gov_up_thr = data[LOAD_W-1:0];
        gov_low_count = '0;
      end
      REG_DOWN_THR: begin
        gov_down_thr = data[LOAD_W-1:0];
        gov_low_count = '0;
      end
      REG_HISTORY: begin
        gov_history = data[HIST_W-1:0];
        gov_low_count = '0;
      end
      REG_DEADLINE: gov_deadline = data[DL_W-1:0];
      REG_MAX_FREQ: gov_max_freq = data[FW-1:0];
      default: ;
    endcase
  endfunction

  function automatic void add_event(logic [TW-1:0] da, logic [TW-1:0] di, logic [FW-1:0] cur);
    directed_rows.push_back('{ROW_EVENT, '0, '0, da, di, cur, 1'b0, '0});
  endfunction

  function automatic void add_checked(logic [TW-1:0] da, logic [TW-1:0] di,
                                      logic [FW-1:0] cur, logic req, logic [FW-1:0] rf,
                                      logic [LOAD_W-1:0] ld);
    directed_rows.push_back('{ROW_EVENT, '0, '0, da, di, cur, 1'b1,
                              freq_request_t'{req, rf, ld}});
  endfunction

  function automatic void add_write(logic [IDX_W-1:0] idx, logic [CW-1:0] data);
    directed_rows.push_back('{ROW_WRITE, idx, data, '0, '0, '0, 1'b0, '0});
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    err_count++;
    if (err_count <= PRINT_LIMIT)
      $display("%0t: %s mismatch: got %0h, expected %0h", $time, what, got, want);
  endtask

  // Bursts of items separated by random gaps, with some long runs back to back.
  task automatic pace();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 23);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Offers one event, waits for it to be taken and records the expected request.
  task automatic send_event(logic [TW-1:0] d_act, logic [TW-1:0] d_idle, logic [FW-1:0] cur,
                            bit typed, freq_request_t fixed);
    freq_request_t predicted;
    tot_active = tot_active + d_act;
    tot_idle = tot_idle + d_idle;
    in_valid <= 1'b1;
    in_total_active <= tot_active;
    in_total_idle <= tot_idle;
    in_current_freq <= cur;
    do begin
      @(posedge clk);
    end while (!in_ready);
    predicted = governor_step(tot_active, tot_idle, cur);
    pending_requests.push_back(typed ? fixed : predicted);
    pace();
  endtask

  // Lets every outstanding result out and the block go quiet.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_requests.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CW-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    governor_write(idx, data);
  endtask

  // Writes all five registers, with random bits above the width of all but the maximum frequency.
  task automatic program_regs(logic [LOAD_W-1:0] up, logic [LOAD_W-1:0] down,
                              logic [HIST_W-1:0] hist, logic [DL_W-1:0] dl,
                              logic [FW-1:0] fmax);
    drain();
    write_reg(REG_UP_THR, (CW'($urandom) << LOAD_W) | CW'(up));
    write_reg(REG_DOWN_THR, (CW'($urandom) << LOAD_W) | CW'(down));
    write_reg(REG_HISTORY, (CW'($urandom) << HIST_W) | CW'(hist));
    write_reg(REG_DEADLINE, (CW'($urandom) << DL_W) | CW'(dl));
    write_reg(REG_MAX_FREQ, CW'(fmax));
    if ($urandom_range(0, 1) == 1)
      write_reg(($urandom_range(0, 1) == 1) ? REG_SPARE_LO : REG_SPARE_HI, CW'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Random events shaped by a target load, mostly low when low_pct is high.
  task automatic run_phase(int n_items, int low_pct, int t_max, bit noise);
    logic [TW-1:0] da;
    logic [TW-1:0] di;
    logic [FW-1:0] cur;
    int span;
    int lim;
    int pct;
    for (int k = 0; k < n_items; k++) begin
      lim = (gov_down_thr > PCT_FULL) ? PCT_FULL : gov_down_thr;
      if (noise && $urandom_range(0, 59) == 0) begin
        da = $urandom;
        di = $urandom;
      end else if ($urandom_range(0, 39) == 0) begin
        da = '0;
        di = '0;
      end else begin
        case ($urandom_range(0, 3))
          0: span = $urandom_range(1, 40);
          1: span = $urandom_range(1, 400);
          default: span = $urandom_range(1, t_max);
        endcase
        if ($urandom_range(0, 99) < low_pct)
          pct = $urandom_range(0, lim);
        else
          pct = $urandom_range(0, PCT_FULL);
        da = TW'(span * pct / PCT_FULL);
        di = TW'(span) - da;
      end
      case ($urandom_range(0, 7))
        0: cur = '0;
        1: cur = '1;
        2: cur = $urandom_range(0, 1000);
        default: cur = $urandom;
      endcase
      send_event(da, di, cur, 1'b0, '0);
    end
  endtask

  // Receiver: picks a new stall pattern each time its 8-bit tick counter wraps.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_mode <= RX_OPEN;
      rx_tick <= '0;
      rx_hold <= 0;
    end else begin
      rx_tick <= rx_tick + 1'b1;
      if (rx_tick == '1)
        rx_mode <= rx_mode_t'($urandom_range(0, 3));
      case (rx_mode)
        RX_OPEN:   out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ready <= (rx_tick[2:0] == 3'd0);
        default: begin
          if (rx_hold != 0) begin
            rx_hold <= rx_hold - 1;
            out_ready <= 1'b0;
          end else begin
            rx_hold <= $urandom_range(5, 40);
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Result checker: each item taken is compared with the oldest expectation.
  always @(posedge clk) begin
    freq_request_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_requests.size() == 0) begin
        report_mismatch("unexpected result", out_requested_freq, '0);
      end else begin
        want = pending_requests.pop_front();
        if (out_request_valid !== want.request)
          report_mismatch("request_valid", out_request_valid, want.request);
        if (out_requested_freq !== want.freq)
          report_mismatch("requested_freq", out_requested_freq, want.freq);
        if (out_load_percent !== want.load)
          report_mismatch("load_percent", out_load_percent, want.load);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    bit                writing;
    logic [LOAD_W-1:0] up_v;
    logic [LOAD_W-1:0] down_v;
    logic [HIST_W-1:0] hist_v;
    logic [DL_W-1:0]   dl_v;
    logic [FW-1:0]     max_v;

    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_total_active <= '0;
    in_total_idle <= '0;
    in_current_freq <= '0;

    gov_up_thr = UP_THR_RST;
    gov_down_thr = DOWN_THR_RST;
    gov_history = HISTORY_RST;
    gov_deadline = DEADLINE_RST;
    gov_max_freq = '1;
    gov_first = 1'b1;
    gov_prev_active = '0;
    gov_prev_idle = '0;
    gov_low_count = '0;
    gov_load = '0;
    tot_active = '0;
    tot_idle = '0;
    burst_left = 0;
    writing = 1'b0;

    // Defaults: first event latches only, zero deltas keep the load.
    add_checked(32'd1000, 32'd5000, 32'd1000, 1'b0, '0, 7'd0);
    add_checked(32'd0, 32'd0, 32'd1000, 1'b0, '0, 7'd0);
    add_checked(32'd10, 32'd90, 32'd1000, 1'b0, '0, 7'd10);
    // Deadline reached but not exceeded, load exactly at the up threshold.
    add_checked(32'd16, 32'd4, 32'd1000, 1'b1, '1, 7'd80);
    // Deadline exceeded alone.
    add_checked(32'd17, 32'd1000, 32'd1000, 1'b1, '1, 7'd1);
    // Totals wrap; largest deltas.
    add_event(32'hFFFF_FF00, 32'hFFFF_FF00, 32'd0);
    add_event(32'd10, 32'd91, 32'hFFFF_FFFF);
    add_event(32'd0, 32'd4096, 32'd7);
    add_checked(32'd10, 32'd0, 32'd3, 1'b1, '1, 7'd100);
    add_event(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1);
    // History of zero: every low-load event scales down at once.
    add_write(REG_HISTORY, 32'hFFFF_FF00);
    add_write(REG_MAX_FREQ, 32'd0);
    add_event(32'd5, 32'd95, 32'hFFFF_FFFF);
    // Deadline request followed by a downscale in the same event.
    add_checked(32'd20, 32'd200, 32'd1000, 1'b1, 32'd90, 7'd9);
    add_checked(32'd10, 32'd0, 32'd55, 1'b1, '0, 7'd100);
    // Thresholds above 100: up never reached, down always.
    add_write(REG_UP_THR, 32'hFFFF_FFFF);
    add_write(REG_DOWN_THR, 32'h0000_007F);
    add_write(REG_DEADLINE, 32'h0000_FFFF);
    add_checked(32'd10, 32'd0, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 7'd100);
    add_write(REG_SPARE_LO, 32'd0);
    add_write(REG_SPARE_HI, 32'hFFFF_FFFF);
    add_write(REG_DEADLINE, 32'hFFFF_0000);
    add_checked(32'd1, 32'd0, 32'd12345, 1'b1, 32'd12345, 7'd100);
    // Up threshold of zero: every event asks for the maximum; then both thresholds at 100.
    add_write(REG_UP_THR, 32'h0000_0080);
    add_write(REG_MAX_FREQ, 32'hFFFF_FFFF);
    add_write(REG_DEADLINE, 32'd16);
    add_write(REG_HISTORY, 32'd255);
    add_write(REG_DOWN_THR, 32'd0);
    add_event(32'd0, 32'd0, 32'd3);
    add_event(32'd0, 32'd50, 32'd3);
    add_write(REG_UP_THR, 32'd100);
    add_write(REG_DOWN_THR, 32'd100);
    add_event(32'd7, 32'd0, 32'd3);
    add_event(32'd1, 32'd1, 32'd3);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed script.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_WRITE) begin
        if (!writing) begin
          drain();
          writing = 1'b1;
        end
        write_reg(directed_rows[r].idx, directed_rows[r].wdata);
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
        end
        send_event(directed_rows[r].d_active, directed_rows[r].d_idle,
                   directed_rows[r].cur_freq, directed_rows[r].typed,
                   directed_rows[r].outcome);
      end
    end

    // Long run of low load with the largest history, long enough to scale down.
    program_regs(7'd127, 7'd100, 8'd255, 16'hFFFF, $urandom);
    run_phase(300, 100, 400, 1'b0);

    // Random settings, extremes included.
    repeat (8) begin
      case ($urandom_range(0, 5))
        0: up_v = 7'd0;
        1: up_v = PCT_FULL;
        2: up_v = 7'd127;
        default: up_v = $urandom_range(40, 100);
      endcase
      case ($urandom_range(0, 5))
        0: down_v = 7'd0;
        1: down_v = PCT_FULL;
        2: down_v = 7'd127;
        default: down_v = $urandom_range(0, 60);
      endcase
      case ($urandom_range(0, 5))
        0: hist_v = 8'd0;
        1: hist_v = 8'd255;
        2: hist_v = $urandom_range(0, 255);
        default: hist_v = $urandom_range(1, 6);
      endcase
      case ($urandom_range(0, 5))
        0: dl_v = 16'd0;
        1: dl_v = 16'hFFFF;
        2: dl_v = $urandom_range(0, 65535);
        default: dl_v = $urandom_range(8, 400);
      endcase
      case ($urandom_range(0, 3))
        0: max_v = '0;
        1: max_v = '1;
        default: max_v = $urandom;
      endcase
      program_regs(up_v, down_v, hist_v, dl_v, max_v);
      run_phase(140, $urandom_range(20, 100),
                ($urandom_range(0, 1) == 1) ? 400 : 70000, 1'b1);
    end

    drain();
    if (err_count == 0 && pending_requests.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
